>>> rtl/core/mwo_pkg.sv
// Package for the multiphase wave oscillator core.
// Holds the shared widths, shape codes, state types, request/response structs
// and the sine and cosine polynomial coefficient table. No dependencies.
package mwo_pkg;

  localparam int PHASE_BITS_DEF      = 32;
  localparam int LEVEL_FRAC_BITS_DEF = 12;

  localparam int STEP_W      = 32;
  localparam int SHIFT_W     = 20;
  localparam int NUM_SHIFT   = 4;
  localparam int CH_W        = 5;
  localparam int LEVEL_W     = 16;
  localparam int SHAPE_W     = 3;
  localparam int U_W         = 32;
  localparam int IN_TDATA_W  = 112;
  localparam int OUT_TDATA_W = 24;

  localparam logic [CH_W-1:0] LAST_CH = 5'd19;

  // Shared multiplier: signed coefficient side times unsigned magnitude side.
  localparam int MUL_A_W = 36;
  localparam int MUL_B_W = 30;
  localparam int PROD_W  = MUL_A_W + MUL_B_W + 1;
  localparam int Z_W     = 27;
  localparam int VAL_W   = 40;

  localparam logic [2:0] COS_ORDER = 3'd4;
  localparam logic [2:0] SIN_ORDER = 3'd3;

  typedef logic [SHAPE_W-1:0] shape_t;

  localparam shape_t SHAPE_SINE   = 3'd0;
  localparam shape_t SHAPE_TRI    = 3'd1;
  localparam shape_t SHAPE_SAW    = 3'd2;
  localparam shape_t SHAPE_SQUARE = 3'd3;
  localparam shape_t SHAPE_RECT   = 3'd4;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_LOAD,
    CS_RUN,
    CS_EMIT
  } core_state_t;

  typedef enum logic [3:0] {
    SH_IDLE,
    SH_OCT,
    SH_SQ,
    SH_Z,
    SH_MUL,
    SH_ADD,
    SH_MULA,
    SH_SINA,
    SH_POST,
    SH_LIN,
    SH_ROUND
  } shp_state_t;

  typedef struct packed {
    logic           start;
    logic [U_W-1:0] u;
    shape_t         shape;
  } shp_req_t;

  typedef struct packed {
    logic               done;
    logic [LEVEL_W-1:0] level;
  } shp_rsp_t;

  // Horner coefficients in Q24, highest order first.
  function automatic logic signed [MUL_A_W-1:0] poly_coef(input logic       is_cos,
                                                          input logic [2:0] idx);
    logic signed [MUL_A_W-1:0] k;
    k = '0;
    if (is_cos) begin
      case (idx)
        3'd0:    k = 36'sd5053686806;
        3'd1:    k = -36'sd7168636974;
        3'd2:    k = 36'sd5447511202;
        3'd3:    k = -36'sd1655844849;
        3'd4:    k = 36'sd83886080;
        default: k = '0;
      endcase
    end else begin
      case (idx)
        3'd0:    k = -36'sd6434553888;
        3'd1:    k = 36'sd6845544469;
        3'd2:    k = -36'sd3467993341;
        3'd3:    k = 36'sd527071788;
        default: k = '0;
      endcase
    end
    return k;
  endfunction

endpackage

>>> rtl/core/mwo_mul.sv
// Shared multiplier of the wave shaper, with a registered product.
// Depends on mwo_pkg for the operand and product widths.
module mwo_mul (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [mwo_pkg::MUL_A_W-1:0]  op_a,
  input  logic        [mwo_pkg::MUL_B_W-1:0]  op_b,
  output logic signed [mwo_pkg::PROD_W-1:0]   prod
);
  import mwo_pkg::*;

  logic signed [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= op_a * $signed({1'b0, op_b});
    end
  end

  assign prod = prod_r;

endmodule

>>> rtl/core/mwo_phase.sv
// Phase accumulator and per-channel phase selection.
// Holds the accumulator and the four user shifts of the current item; gives the
// 32-bit cycle fraction of the selected channel. Depends on mwo_pkg.
module mwo_phase #(
  parameter int PHASE_BITS = mwo_pkg::PHASE_BITS_DEF
) (
  input  logic                                             clk,
  input  logic                                             rst_n,
  input  logic                                             load,
  input  logic [mwo_pkg::STEP_W-1:0]                       phase_step,
  input  logic [mwo_pkg::NUM_SHIFT*mwo_pkg::SHIFT_W-1:0]   shifts,
  input  logic [mwo_pkg::CH_W-1:0]                         ch,
  output logic [mwo_pkg::U_W-1:0]                          u
);
  import mwo_pkg::*;

  localparam logic [63:0] ONE   = 64'd1 << PHASE_BITS;
  localparam logic [PHASE_BITS-1:0] OFF12 = PHASE_BITS'((ONE + 64'd6) / 64'd12);
  localparam logic [PHASE_BITS-1:0] OFF8  = PHASE_BITS'(ONE >> 3);
  localparam logic [PHASE_BITS-1:0] OFF6  = PHASE_BITS'((ONE + 64'd3) / 64'd6);
  localparam int SHW = PHASE_BITS + 4;

  logic [PHASE_BITS-1:0]    acc_r;
  logic [SHIFT_W-1:0]       shift_r [NUM_SHIFT];
  logic [PHASE_BITS-1:0]    off;
  logic [PHASE_BITS-1:0]    quarter;
  logic [SHW-1:0]           sh_wide;
  logic [PHASE_BITS-1:0]    p;
  logic [PHASE_BITS+15:0]   p_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (load) begin
      acc_r <= acc_r + PHASE_BITS'(phase_step);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < NUM_SHIFT; i++) begin
        shift_r[i] <= shifts[i*SHIFT_W +: SHIFT_W];
      end
    end
  end

  always_comb begin
    case (ch[1:0])
      2'd0:    off = '0;
      2'd1:    off = OFF12;
      2'd2:    off = OFF8;
      2'd3:    off = OFF6;
      default: off = '0;
    endcase
    // The quarter-cycle group only touches the top two phase bits.
    quarter = {ch[3:2], {(PHASE_BITS-2){1'b0}}};
    // User shifts have 16 fractional bits and wrap modulo one cycle.
    sh_wide = SHW'(shift_r[ch[1:0]]) << (PHASE_BITS - 16);
    if (ch[4]) begin
      p = acc_r + sh_wide[PHASE_BITS-1:0];
    end else begin
      p = acc_r + off + quarter;
    end
    p_ext = {p, 16'h0000};
    u     = p_ext[PHASE_BITS+15 -: U_W];
  end

endmodule

>>> rtl/core/mwo_shaper.sv
// Wave shaper: turns one 32-bit cycle fraction into a saturated level.
// Sine uses octant reduction and Horner steps on the shared multiplier
// (mwo_mul) under a small sequencer. Depends on mwo_pkg and mwo_mul.
module mwo_shaper #(
  parameter int LEVEL_FRAC_BITS = mwo_pkg::LEVEL_FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  mwo_pkg::shp_req_t req,
  output mwo_pkg::shp_rsp_t rsp
);
  import mwo_pkg::*;

  localparam logic signed [PROD_W-1:0] HALF_P = PROD_W'(64'h8000_0000);
  localparam logic signed [VAL_W-1:0]  FIVE_V = VAL_W'(64'h5_0000_0000);
  localparam logic signed [VAL_W-1:0]  TEN_V  = VAL_W'(64'hA_0000_0000);
  localparam logic signed [VAL_W-1:0]  HALF_L = VAL_W'(1) <<< (31 - LEVEL_FRAC_BITS);
  localparam logic signed [VAL_W-1:0]  LIM    = VAL_W'(5) <<< LEVEL_FRAC_BITS;

  shp_state_t               state_r, state_nxt;
  logic [U_W-1:0]           u_r, u_nxt;
  shape_t                   shape_r, shape_nxt;
  logic [1:0]               q_r, q_nxt;
  logic                     neg_r, neg_nxt;
  logic [MUL_B_W-1:0]       a_r, a_nxt;
  logic [Z_W-1:0]           z_r, z_nxt;
  logic signed [MUL_A_W-1:0] y_r, y_nxt;
  logic [2:0]               step_r, step_nxt;
  logic signed [VAL_W-1:0]  v_r, v_nxt;
  logic [LEVEL_W-1:0]       level_r, level_nxt;
  logic                     done_r, done_nxt;

  logic                      mul_en;
  logic signed [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0]        mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  prod_sh;

  logic [3:0]                oct_hi;
  logic [3:0]                oct_j;
  logic signed [33:0]        oct_r;
  logic signed [33:0]        oct_abs;
  logic                      is_cos;
  logic signed [MUL_A_W-1:0] s_val;
  logic signed [VAL_W-1:0]   v_sin;
  logic signed [VAL_W-1:0]   v_abs;
  logic signed [VAL_W-1:0]   u_v;
  logic signed [VAL_W-1:0]   tri_d;
  logic signed [VAL_W-1:0]   v_lin;
  logic signed [VAL_W-1:0]   rnd;

  mwo_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SH_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    u_r     <= u_nxt;
    shape_r <= shape_nxt;
    q_r     <= q_nxt;
    neg_r   <= neg_nxt;
    a_r     <= a_nxt;
    z_r     <= z_nxt;
    y_r     <= y_nxt;
    step_r  <= step_nxt;
    v_r     <= v_nxt;
    level_r <= level_nxt;
  end

  always_comb begin
    // Octant reduction: nearest multiple of a quarter cycle, residue in r.
    oct_hi  = {1'b0, u_r[31:29]} + 4'd1;
    oct_j   = {oct_hi[3:1], 1'b0};
    oct_r   = $signed({2'b00, u_r}) - $signed({1'b0, oct_j, 29'h0});
    oct_abs = oct_r[33] ? -oct_r : oct_r;

    prod_sh = (prod + HALF_P) >>> 32;
    is_cos  = q_r[0];

    // Sine branch carries the residue sign; upper quadrants flip the result.
    s_val = (!is_cos && neg_r) ? -y_r : y_r;
    if (q_r[1]) begin
      s_val = -s_val;
    end
    v_sin = VAL_W'(s_val) <<< 8;
    v_abs = v_sin[VAL_W-1] ? -v_sin : v_sin;

    u_v   = $signed({{(VAL_W-U_W){1'b0}}, u_r});
    tri_d = (u_v <<< 4) + (u_v <<< 2) - TEN_V;
    case (shape_r)
      SHAPE_TRI:    v_lin = FIVE_V - (tri_d[VAL_W-1] ? -tri_d : tri_d);
      SHAPE_SAW:    v_lin = (u_v <<< 3) + (u_v <<< 1) - FIVE_V;
      SHAPE_SQUARE: v_lin = u_r[31] ? -FIVE_V : FIVE_V;
      default:      v_lin = FIVE_V;
    endcase

    rnd = (v_r + HALF_L) >>> (32 - LEVEL_FRAC_BITS);
    if (rnd > LIM) begin
      rnd = LIM;
    end else if (rnd < -LIM) begin
      rnd = -LIM;
    end
  end

  always_comb begin
    state_nxt = state_r;
    u_nxt     = u_r;
    shape_nxt = shape_r;
    q_nxt     = q_r;
    neg_nxt   = neg_r;
    a_nxt     = a_r;
    z_nxt     = z_r;
    y_nxt     = y_r;
    step_nxt  = step_r;
    v_nxt     = v_r;
    level_nxt = level_r;
    done_nxt  = 1'b0;
    mul_en    = 1'b0;
    mul_a     = y_r;
    mul_b     = a_r;

    case (state_r)
      SH_IDLE: begin
        if (req.start) begin
          u_nxt     = req.u;
          // Codes above rectified sine behave as rectified sine.
          shape_nxt = (req.shape > SHAPE_RECT) ? SHAPE_RECT : req.shape;
          if (req.shape == SHAPE_SINE || req.shape >= SHAPE_RECT) begin
            state_nxt = SH_OCT;
          end else begin
            state_nxt = SH_LIN;
          end
        end
      end
      SH_OCT: begin
        q_nxt     = oct_j[2:1];
        neg_nxt   = oct_r[33];
        a_nxt     = oct_abs[MUL_B_W-1:0];
        state_nxt = SH_SQ;
      end
      SH_SQ: begin
        mul_en    = 1'b1;
        mul_a     = $signed({{(MUL_A_W-MUL_B_W){1'b0}}, a_r});
        mul_b     = a_r;
        state_nxt = SH_Z;
      end
      SH_Z: begin
        z_nxt     = prod_sh[Z_W-1:0];
        y_nxt     = poly_coef(is_cos, 3'd0);
        step_nxt  = 3'd1;
        state_nxt = SH_MUL;
      end
      SH_MUL: begin
        mul_en    = 1'b1;
        mul_a     = y_r;
        mul_b     = MUL_B_W'(z_r);
        state_nxt = SH_ADD;
      end
      SH_ADD: begin
        y_nxt    = prod_sh[MUL_A_W-1:0] + poly_coef(is_cos, step_r);
        step_nxt = step_r + 3'd1;
        if (is_cos && step_r == COS_ORDER) begin
          state_nxt = SH_POST;
        end else if (!is_cos && step_r == SIN_ORDER) begin
          state_nxt = SH_MULA;
        end else begin
          state_nxt = SH_MUL;
        end
      end
      SH_MULA: begin
        mul_en    = 1'b1;
        mul_a     = y_r;
        mul_b     = a_r;
        state_nxt = SH_SINA;
      end
      SH_SINA: begin
        y_nxt     = prod_sh[MUL_A_W-1:0];
        state_nxt = SH_POST;
      end
      SH_POST: begin
        if (shape_r == SHAPE_SINE) begin
          v_nxt = v_sin;
        end else begin
          v_nxt = (v_abs <<< 1) - FIVE_V;
        end
        state_nxt = SH_ROUND;
      end
      SH_LIN: begin
        v_nxt     = v_lin;
        state_nxt = SH_ROUND;
      end
      SH_ROUND: begin
        level_nxt = rnd[LEVEL_W-1:0];
        done_nxt  = 1'b1;
        state_nxt = SH_IDLE;
      end
      default: begin
        state_nxt = SH_IDLE;
      end
    endcase
  end

  assign rsp.done  = done_r;
  assign rsp.level = level_r;

endmodule

>>> rtl/core/multiphase_wave_oscillator_core.sv
// Multiphase wave oscillator, top level.
// Usage:
//   Each item on the in_ channel is one sample tick. It carries the phase step
//   and four user phase shifts. The tick adds the step to the phase
//   accumulator and then produces twenty result items on the out_ channel,
//   channels 0 to 19 in order, tlast set on channel 19.
//   The wave shape is a configuration register written through cfg_wr_en and
//   cfg_wr_data; the user must write it only while idle, as the block does not enforce this.
//   in_tready is low from the accepted item until the twentieth level is in
//   the output register, so the block takes no new tick while one is running.
//   One level of sine or rectified sine takes octant setup and five steps of
//   the shared multiplier; the other shapes take a direct linear computation.
//   A stalled receiver holds the output register; the next level is computed
//   meanwhile and then waits, so a stall only stretches the item by the part
//   that outlasts that computation.
//   Reset clears the phase accumulator, sets the shape to sine and empties the
//   output register.
// Depends on mwo_pkg, mwo_phase and mwo_shaper.
module multiphase_wave_oscillator_core #(
  parameter int PHASE_BITS      = mwo_pkg::PHASE_BITS_DEF,
  parameter int LEVEL_FRAC_BITS = mwo_pkg::LEVEL_FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // phase_step[31:0], shift_a[51:32], shift_b[71:52], shift_c[91:72], shift_d[111:92]
  input  logic [mwo_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // channel[4:0], level[20:5], zero fill[23:21]
  output logic [mwo_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                               out_tlast,
  input  logic                               cfg_wr_en,
  input  logic [mwo_pkg::SHAPE_W-1:0]        cfg_wr_data
);
  import mwo_pkg::*;

  core_state_t          state_r, state_nxt;
  logic [CH_W-1:0]      ch_r, ch_nxt;
  shape_t               wave_shape_r;
  logic                 out_valid_r, out_valid_nxt;
  logic [CH_W-1:0]      out_ch_r, out_ch_nxt;
  logic [LEVEL_W-1:0]   out_level_r, out_level_nxt;
  logic                 out_last_r, out_last_nxt;
  logic                 accept;
  logic [U_W-1:0]       ch_u;
  shp_req_t             shp_req;
  shp_rsp_t             shp_rsp;

  assign in_tready = (state_r == CS_IDLE);
  assign accept    = in_tvalid && in_tready;

  mwo_phase #(
    .PHASE_BITS (PHASE_BITS)
  ) u_phase (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (accept),
    .phase_step (in_tdata[STEP_W-1:0]),
    .shifts     (in_tdata[IN_TDATA_W-1:STEP_W]),
    .ch         (ch_r),
    .u          (ch_u)
  );

  mwo_shaper #(
    .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
  ) u_shaper (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (shp_req),
    .rsp   (shp_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= CS_IDLE;
      wave_shape_r <= SHAPE_SINE;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        wave_shape_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    ch_r        <= ch_nxt;
    out_ch_r    <= out_ch_nxt;
    out_level_r <= out_level_nxt;
    out_last_r  <= out_last_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    ch_nxt         = ch_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_ch_nxt     = out_ch_r;
    out_level_nxt  = out_level_r;
    out_last_nxt   = out_last_r;
    shp_req.start  = 1'b0;
    shp_req.u      = ch_u;
    shp_req.shape  = wave_shape_r;

    case (state_r)
      CS_IDLE: begin
        if (accept) begin
          ch_nxt    = '0;
          state_nxt = CS_LOAD;
        end
      end
      // The channel index and accumulator are settled here, so the phase is valid.
      CS_LOAD: begin
        shp_req.start = 1'b1;
        state_nxt     = CS_RUN;
      end
      CS_RUN: begin
        if (shp_rsp.done) begin
          state_nxt = CS_EMIT;
        end
      end
      CS_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_ch_nxt    = ch_r;
          out_level_nxt = shp_rsp.level;
          out_last_nxt  = (ch_r == LAST_CH);
          if (ch_r == LAST_CH) begin
            state_nxt = CS_IDLE;
          end else begin
            ch_nxt    = ch_r + 5'd1;
            state_nxt = CS_LOAD;
          end
        end
      end
      default: begin
        state_nxt = CS_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-LEVEL_W-CH_W){1'b0}}, out_level_r, out_ch_r};
  assign out_tlast  = out_last_r;

endmodule

>>> rtl/core/mwo_checker.sv
// Port-level checker for the multiphase wave oscillator core, bound to the top.
// Watches reset, the busy window after an item, output stalls and channel
// numbering. Depends on mwo_pkg.
module mwo_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [mwo_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tlast
);
  import mwo_pkg::*;

  // After reset the block is empty and ready for an item.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("block not idle after reset");

  // An accepted item makes the block busy, so in_tready drops.
  a_busy_after_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("item accepted while the previous one is running");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed during stall");

  a_last_channel: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tdata[CH_W-1:0] == LAST_CH)))
    else $error("tlast does not mark the last channel");

  a_channel_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[CH_W-1:0] <= LAST_CH)
    else $error("channel index out of range");

endmodule

bind multiphase_wave_oscillator_core mwo_checker u_mwo_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_tvalid   (in_tvalid),
  .in_tready   (in_tready),
  .out_tvalid  (out_tvalid),
  .out_tready  (out_tready),
  .out_tdata   (out_tdata),
  .out_tlast   (out_tlast)
);

>>> bench/tb_multiphase_wave_oscillator_core.sv
// Self-checking bench for the multiphase wave oscillator core: it drives sample ticks,
// predicts all twenty levels of each tick in every wave shape and checks them in order.
// Depends on mwo_pkg and the multiphase_wave_oscillator_core RTL.

typedef struct packed {
  logic [3:0][19:0] shift;  // shift_d .. shift_a, shift_a in the lowest bits
  logic [31:0]      step;
} tick_t;

typedef struct packed {
  logic [4:0]  channel;
  logic [15:0] level;
  logic        last;
} level_item_t;

class wave_scoreboard;
  level_item_t     levels_due[$];
  bit [31:0]       phase;
  mwo_pkg::shape_t shape;
  int unsigned     mismatches;

  function new();
    phase      = '0;
    shape      = mwo_pkg::SHAPE_SINE;
    mismatches = 0;
  endfunction

  function void set_shape(mwo_pkg::shape_t s);
    shape = s;
  endfunction

  function int pending();
    return levels_due.size();
  endfunction

  function int failures();
    return mismatches + levels_due.size();
  endfunction

  // Half-up rounding of a product that carries 32 extra fractional bits.
  function longint round32(longint v);
    return (v + (64'sd1 <<< 31)) >>> 32;
  endfunction

  // 5*sin(2*pi*u/2^32) in volts with 32 fractional bits, by octant reduction.
  function longint sine_volts(bit [31:0] u);
    longint kc[5];
    longint ks[4];
    longint uu, j, r, a, z, yc, ys, v;
    bit     neg;
    int     i;
    kc = '{64'sd5053686806, -64'sd7168636974, 64'sd5447511202, -64'sd1655844849,
           64'sd83886080};
    ks = '{-64'sd6434553888, 64'sd6845544469, -64'sd3467993341, 64'sd527071788};
    uu = {32'd0, u};
    j = (((uu >>> 29) + 1) >>> 1) <<< 1;
    r = uu - (j <<< 29);
    neg = r < 0;
    a = neg ? -r : r;
    z = (a * a + (64'sd1 <<< 31)) >>> 32;
    yc = kc[0];
    for (i = 1; i < 5; i++) yc = round32(yc * z) + kc[i];
    ys = ks[0];
    for (i = 1; i < 4; i++) ys = round32(ys * z) + ks[i];
    ys = round32(ys * a);
    if (neg) ys = -ys;
    // Quadrant is j/2 mod 4: bit 1 of j picks cosine, bit 2 flips the sign.
    v = j[1] ? yc : ys;
    if (j[2]) v = -v;
    return v * 256;
  endfunction

  function logic [15:0] level_at(bit [31:0] u);
    longint one, uu, v, d, s;
    one = 64'sd1 <<< 32;
    uu  = {32'd0, u};
    case (shape)
      mwo_pkg::SHAPE_SINE:   v = sine_volts(u);
      mwo_pkg::SHAPE_TRI: begin
        d = 20 * uu - 10 * one;
        v = 5 * one - (d < 0 ? -d : d);
      end
      mwo_pkg::SHAPE_SAW:    v = 10 * uu - 5 * one;
      mwo_pkg::SHAPE_SQUARE: v = u[31] ? -5 * one : 5 * one;
      // Rectified sine; the spare codes behave the same way.
      default: begin
        s = sine_volts(u);
        v = 2 * (s < 0 ? -s : s) - 5 * one;
      end
    endcase
    // Down to Q3.12 with half-up rounding, then clamp to +-5 V.
    v = (v + (64'sd1 <<< 19)) >>> 20;
    if (v > 20480) v = 20480;
    if (v < -20480) v = -20480;
    return v[15:0];
  endfunction

  function void note_tick(bit [31:0] step, bit [3:0][19:0] shift);
    bit [31:0]   offs[4];
    bit [31:0]   u;
    level_item_t e;
    int          c;
    // 0, 1/12, 1/8 and 1/6 of a cycle, each rounded to the nearest step.
    offs = '{32'd0, 32'd357913941, 32'h2000_0000, 32'd715827883};
    phase = phase + step;
    for (c = 0; c < 20; c++) begin
      if (c < 16) u = phase + offs[c % 4] + {c[3:2], 30'd0};
      else u = phase + {shift[c - 16][15:0], 16'd0};
      e.channel = c[4:0];
      e.level   = level_at(u);
      e.last    = (c == 19);
      levels_due.push_back(e);
    end
  endfunction

  function void check_level(logic [4:0] channel, logic [15:0] level, logic last);
    level_item_t e;
    if (levels_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: unexpected item channel=%0d level=%0d last=%0b",
                 $realtime, channel, $signed(level), last);
      return;
    end
    e = levels_due.pop_front();
    if (e.channel !== channel || e.level !== level || e.last !== last) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: mismatch expected ch=%0d level=%0d last=%0b, got ch=%0d level=%0d last=%0b",
                 $realtime, e.channel, $signed(e.level), e.last,
                 channel, $signed(level), last);
    end
  endfunction
endclass

module tb_multiphase_wave_oscillator_core;
  timeunit 1ns;
  timeprecision 1ps;
  import mwo_pkg::*;

  localparam shape_t SHAPE_SPARE_5 = 3'd5;
  localparam shape_t SHAPE_SPARE_6 = 3'd6;
  localparam shape_t SHAPE_SPARE_7 = 3'd7;
  localparam int     LONG_HOLD     = 2000;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   cfg_wr_en;
  logic [SHAPE_W-1:0]     cfg_wr_data;

  wave_scoreboard sb = new();

  int src_idle_pct = 0;
  int stall_pct    = 0;
  int hold_req     = 0;
  int hold_seen    = 0;
  int hold_left    = 0;

  multiphase_wave_oscillator_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Receiver: random stalls, or a long hold-off whenever one is requested.
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen  <= hold_req;
      hold_left  <= LONG_HOLD;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_tick(in_tdata[31:0], in_tdata[111:32]);
      if (out_tvalid && out_tready)
        sb.check_level(out_tdata[4:0], out_tdata[20:5], out_tlast);
    end
  end

  function automatic tick_t make_tick(bit [31:0] step, int a, int b, int c, int d);
    tick_t t;
    t.step     = step;
    t.shift[0] = a[19:0];
    t.shift[1] = b[19:0];
    t.shift[2] = c[19:0];
    t.shift[3] = d[19:0];
    return t;
  endfunction

  function automatic tick_t random_tick();
    tick_t t;
    int    k;
    int    i;
    k = $urandom_range(0, 9);
    if (k < 2) t.step = $urandom_range(0, 16'hFFFF);
    else if (k < 4) t.step = ($urandom_range(0, 7) << 29) + $urandom_range(0, 2) - 1;
    else t.step = $urandom();
    for (i = 0; i < 4; i++) begin
      k = $urandom_range(0, 15);
      if (k == 0) t.shift[i] = 20'sd327680;
      else if (k == 1) t.shift[i] = -20'sd327680;
      else if (k < 4) t.shift[i] = 20'($urandom());
      else t.shift[i] = 20'($urandom_range(0, 655360) - 327680);
    end
    return t;
  endfunction

  // in_tvalid is only lowered when a gap is taken, so a back-to-back item keeps it high.
  task automatic send_tick(input tick_t t);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < src_idle_pct) gap++;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= t;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_shape(input shape_t s);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= s;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_shape(s);
  endtask

  initial begin
    shape_t other_shapes[7];
    shape_t phase_shapes[8];
    int     src_pct_of[4];
    int     snk_pct_of[4];
    int     p, n;
    other_shapes = '{SHAPE_TRI, SHAPE_SAW, SHAPE_SQUARE, SHAPE_RECT,
                     SHAPE_SPARE_5, SHAPE_SPARE_6, SHAPE_SPARE_7};
    phase_shapes = '{SHAPE_RECT, SHAPE_SINE, SHAPE_SAW, SHAPE_TRI,
                     SHAPE_SQUARE, SHAPE_SPARE_6, SHAPE_SINE, SHAPE_SPARE_7};
    src_pct_of = '{0, 66, 0, 21};
    snk_pct_of = '{0, 0, 66, 21};
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    out_tready  = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = SHAPE_SINE;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Sine from reset: zero step, octant edges, half cycle, full-scale wrap and shifts
    // at their +-327680 limits.
    send_tick(make_tick(32'h0000_0000, 327680, -327680, 0, 1));
    send_tick(make_tick(32'h2000_0000, 16384, -16384, 32768, 65535));
    send_tick(make_tick(32'h1FFF_FFFF, -1, 65536, -65536, 163840));
    send_tick(make_tick(32'h8000_0000, 8192, -8192, 1, -1));
    send_tick(make_tick(32'hFFFF_FFFF, 300000, -300000, 49152, -49152));
    send_tick(make_tick(32'h0000_0001, 0, 0, 0, 0));
    foreach (other_shapes[i]) begin
      wait_drained();
      write_shape(other_shapes[i]);
      send_tick(make_tick(32'h0000_0000, 0, 16384, 32768, 49152));
      send_tick(make_tick(32'h7FFF_FFFF, 327680, -327680, 21845, -21845));
    end

    for (p = 0; p < 8; p++) begin
      wait_drained();
      write_shape(phase_shapes[p]);
      src_idle_pct = src_pct_of[p % 4];
      stall_pct   <= snk_pct_of[p % 4];
      // Hold the receiver off long enough that the core backs up into its input.
      if (p == 2) hold_req <= hold_req + 1;
      for (n = 0; n < 25; n++) begin
        if (p == 5 && n == 12) wait_drained();
        send_tick(random_tick());
      end
    end

    wait_drained();
    repeat (64) @(posedge clk);
    if (sb.failures() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #(20_000_000);
    $display("Verification failed");
    $finish;
  end
endmodule
